FILE: sv/ssq_pkg.sv
// shared constants, types and codes for the single-server queue event stepper
package ssq_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int TIME_W   = 48;
  localparam int SAMPLE_W = 32;
  localparam int ACC_W    = 64;
  localparam int COUNT_W  = 32;
  localparam int KIND_W   = 2;
  localparam int QLEN_W   = 8;

  localparam logic [COUNT_W-1:0] REQUIRED_RESET = COUNT_W'(1000);
  localparam logic [TIME_W-1:0]  TIME_MAX       = '1;
  localparam logic [ACC_W-1:0]   ACC_MAX        = '1;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic [KIND_W-1:0] EV_NONE      = 2'd0;
  localparam logic [KIND_W-1:0] EV_ARRIVAL   = 2'd1;
  localparam logic [KIND_W-1:0] EV_DEPARTURE = 2'd2;

  typedef struct packed {
    logic                command;
    logic [SAMPLE_W-1:0] interarrival_sample;
    logic [SAMPLE_W-1:0] service_sample;
  } ssq_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  event_kind;
    logic [TIME_W-1:0]  clock_now;
    logic [QLEN_W-1:0]  queue_length;
    logic               server_busy;
    logic [COUNT_W-1:0] customers_delayed;
    logic [ACC_W-1:0]   total_delay;
    logic [ACC_W-1:0]   area_queue;
    logic [ACC_W-1:0]   area_busy;
    logic               finished;
    logic               overflow_error;
  } ssq_result_t;

  typedef struct packed {
    logic [TIME_W-1:0]  clock_time;
    logic [TIME_W-1:0]  next_arrival_time;
    logic [TIME_W-1:0]  next_departure_time;
    logic               departure_pending;
    logic [PTR_W-1:0]   head_pointer;
    logic [PTR_W-1:0]   tail_pointer;
    logic [CNT_W-1:0]   waiting_count;
    logic               busy;
    logic [COUNT_W-1:0] served_count;
    logic [ACC_W-1:0]   delay_sum;
    logic [ACC_W-1:0]   queue_area_sum;
    logic [ACC_W-1:0]   busy_area_sum;
    logic               overflow;
  } ssq_state_t;

  typedef struct packed {
    logic              en;
    logic [PTR_W-1:0]  addr;
    logic [TIME_W-1:0] data;
  } ssq_wr_t;

endpackage

FILE: sv/ssq_intf.sv
// valid/ready channel interfaces for event commands and event results
interface ssq_item_if;
  import ssq_pkg::*;

  logic                valid;
  logic                ready;
  logic                command;
  logic [SAMPLE_W-1:0] interarrival_sample;
  logic [SAMPLE_W-1:0] service_sample;

  modport source (output valid, output command, output interarrival_sample,
                  output service_sample, input ready);
  modport sink   (input valid, input command, input interarrival_sample,
                  input service_sample, output ready);
endinterface

interface ssq_result_if;
  import ssq_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  event_kind;
  logic [TIME_W-1:0]  clock_now;
  logic [QLEN_W-1:0]  queue_length;
  logic               server_busy;
  logic [COUNT_W-1:0] customers_delayed;
  logic [ACC_W-1:0]   total_delay;
  logic [ACC_W-1:0]   area_queue;
  logic [ACC_W-1:0]   area_busy;
  logic               finished;
  logic               overflow_error;

  modport source (output valid, output event_kind, output clock_now, output queue_length,
                  output server_busy, output customers_delayed, output total_delay,
                  output area_queue, output area_busy, output finished,
                  output overflow_error, input ready);
  modport sink   (input valid, input event_kind, input clock_now, input queue_length,
                  input server_busy, input customers_delayed, input total_delay,
                  input area_queue, input area_busy, input finished,
                  input overflow_error, output ready);
endinterface

FILE: sv/ssq_ram.sv
// generic single-write, single-read ram with registered read data
module ssq_ram #(
  parameter int Width = 48,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/ssq_step.sv
// event selection, statistics update and queue bookkeeping for one command
module ssq_step (
  input  ssq_pkg::ssq_state_t            state_i,
  input  ssq_pkg::ssq_item_t             item_i,
  input  logic [ssq_pkg::COUNT_W-1:0]    required_i,
  input  logic [ssq_pkg::TIME_W-1:0]     head_stamp_i,
  output ssq_pkg::ssq_state_t            state_o,
  output ssq_pkg::ssq_wr_t               wr_o,
  output ssq_pkg::ssq_result_t           result_o
);
  import ssq_pkg::*;

  function automatic logic [TIME_W-1:0] time_plus(input logic [TIME_W-1:0]   t,
                                                  input logic [SAMPLE_W-1:0] s);
    logic [TIME_W:0] sum;
    sum = {1'b0, t} + (TIME_W+1)'(s);
    return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  endfunction

  function automatic logic [ACC_W-1:0] sat_acc(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  logic                      finished_now;
  logic                      is_dep;
  logic [TIME_W-1:0]         new_time;
  logic [TIME_W-1:0]         elapsed;
  logic [TIME_W-1:0]         wait_time;
  logic [CNT_W+TIME_W-1:0]   q_inc;
  logic                      start_svc;
  logic [KIND_W-1:0]         kind;
  ssq_state_t                nx;
  ssq_wr_t                   wr;

  assign finished_now = state_i.served_count >= required_i;
  // an arrival wins a tie and is the only choice with no departure pending
  assign is_dep   = state_i.departure_pending &&
                    (state_i.next_departure_time < state_i.next_arrival_time);
  assign new_time = is_dep ? state_i.next_departure_time : state_i.next_arrival_time;
  assign elapsed  = (new_time > state_i.clock_time) ? new_time - state_i.clock_time : '0;
  assign q_inc    = (CNT_W+TIME_W)'(state_i.waiting_count) * (CNT_W+TIME_W)'(elapsed);
  assign wait_time = (new_time > head_stamp_i) ? new_time - head_stamp_i : '0;

  always_comb begin
    nx        = state_i;
    kind      = EV_NONE;
    start_svc = 1'b0;
    wr.en     = 1'b0;
    wr.addr   = state_i.tail_pointer;
    wr.data   = new_time;
    if (item_i.command == CMD_START) begin
      nx = '0;
      nx.next_arrival_time = time_plus('0, item_i.interarrival_sample);
    end else if (!finished_now) begin
      nx.clock_time     = new_time;
      nx.queue_area_sum = sat_acc(state_i.queue_area_sum, ACC_W'(q_inc));
      if (state_i.busy) begin
        nx.busy_area_sum = sat_acc(state_i.busy_area_sum, ACC_W'(elapsed));
      end
      if (!is_dep) begin
        kind = EV_ARRIVAL;
        nx.next_arrival_time = time_plus(new_time, item_i.interarrival_sample);
        if (state_i.busy) begin
          if (state_i.waiting_count >= CNT_W'(QUEUE_DEPTH)) begin
            nx.overflow = 1'b1;
          end else begin
            wr.en            = 1'b1;
            nx.tail_pointer  = ring_next(state_i.tail_pointer);
            nx.waiting_count = state_i.waiting_count + CNT_W'(1);
          end
        end else begin
          nx.busy   = 1'b1;
          start_svc = 1'b1;
        end
      end else begin
        kind = EV_DEPARTURE;
        if (state_i.waiting_count == '0) begin
          nx.busy              = 1'b0;
          nx.departure_pending = 1'b0;
        end else begin
          nx.head_pointer  = ring_next(state_i.head_pointer);
          nx.waiting_count = state_i.waiting_count - CNT_W'(1);
          nx.delay_sum     = sat_acc(state_i.delay_sum, ACC_W'(wait_time));
          start_svc        = 1'b1;
        end
      end
      if (start_svc) begin
        if (!(&state_i.served_count)) begin
          nx.served_count = state_i.served_count + COUNT_W'(1);
        end
        nx.next_departure_time = time_plus(new_time, item_i.service_sample);
        nx.departure_pending   = 1'b1;
      end
    end
  end

  assign state_o = nx;
  assign wr_o    = wr;

  assign result_o.event_kind        = kind;
  assign result_o.clock_now         = nx.clock_time;
  assign result_o.queue_length      = QLEN_W'(nx.waiting_count);
  assign result_o.server_busy       = nx.busy;
  assign result_o.customers_delayed = nx.served_count;
  assign result_o.total_delay       = nx.delay_sum;
  assign result_o.area_queue        = nx.queue_area_sum;
  assign result_o.area_busy         = nx.busy_area_sum;
  assign result_o.finished          = nx.served_count >= required_i;
  assign result_o.overflow_error    = nx.overflow;

endmodule

FILE: sv/single_server_queue_event_step_core.sv
// Single-server FIFO queue event stepper. Each transfer on item_i carries a start or a step
// command and yields exactly one transfer on result_o. Commands go through an input register,
// combinational event logic (time compare, elapsed-time multiply-accumulate, stamp queue
// access) and a result register; one command is taken every cycle while result_o keeps up.
// Arrival stamps live in a 128-entry ram; the head stamp is read ahead via the registered read
// port, bypassed for a stamp written that cycle. The user must write customers_required via
// cfg_we_i/cfg_data_i only while no command is in flight; the block does not enforce this.
module single_server_queue_event_step_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ssq_pkg::COUNT_W-1:0] cfg_data_i,
  ssq_item_if.sink                    item_i,
  ssq_result_if.source                result_o
);
  import ssq_pkg::*;

  logic [COUNT_W-1:0] required_q;
  ssq_item_t          item_q;
  logic               item_valid_q;
  ssq_state_t         st_q, st_d;
  ssq_result_t        res_q, res_d;
  logic               out_valid_q;
  ssq_wr_t            wr;
  logic               advance;
  logic [PTR_W-1:0]   head_d;
  logic [TIME_W-1:0]  ram_rdata;
  logic [TIME_W-1:0]  head_stamp;
  logic               byp_valid_q;
  logic [TIME_W-1:0]  byp_q;

  assign advance      = item_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !item_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      required_q <= REQUIRED_RESET;
    end else if (cfg_we_i) begin
      required_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      item_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.ready && item_i.valid) begin
      item_q.command             <= item_i.command;
      item_q.interarrival_sample <= item_i.interarrival_sample;
      item_q.service_sample      <= item_i.service_sample;
    end
  end

  ssq_step u_step (
    .state_i      (st_q),
    .item_i       (item_q),
    .required_i   (required_q),
    .head_stamp_i (head_stamp),
    .state_o      (st_d),
    .wr_o         (wr),
    .result_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // read the head entry ahead of its use, addressing the ram with the next head pointer
  assign head_d = advance ? st_d.head_pointer : st_q.head_pointer;

  ssq_ram #(
    .Width (TIME_W),
    .Depth (QUEUE_DEPTH)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (advance && wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .raddr_i (head_d),
    .rdata_o (ram_rdata)
  );

  // stamp written to the head slot this cycle is not yet in the read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_valid_q <= 1'b0;
    end else begin
      byp_valid_q <= advance && wr.en && (wr.addr == head_d);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_q <= wr.data;
  end

  assign head_stamp = byp_valid_q ? byp_q : ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid             = out_valid_q;
  assign result_o.event_kind        = res_q.event_kind;
  assign result_o.clock_now         = res_q.clock_now;
  assign result_o.queue_length      = res_q.queue_length;
  assign result_o.server_busy       = res_q.server_busy;
  assign result_o.customers_delayed = res_q.customers_delayed;
  assign result_o.total_delay       = res_q.total_delay;
  assign result_o.area_queue        = res_q.area_queue;
  assign result_o.area_busy         = res_q.area_busy;
  assign result_o.finished          = res_q.finished;
  assign result_o.overflow_error    = res_q.overflow_error;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.waiting_count <= CNT_W'(QUEUE_DEPTH))
    else $error("waiting count above queue depth");

  a_busy_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.busy == st_q.departure_pending)
    else $error("server busy and departure pending disagree");

  a_idle_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_q.busy |-> (st_q.waiting_count == '0))
    else $error("customers waiting while server idle");

  a_clock_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_q.command == CMD_STEP) |=> (st_q.clock_time >= $past(st_q.clock_time)))
    else $error("simulation clock moved backward on a step");

endmodule
